// ===== rtl/core/hash_bucket_insert_probe_split_top_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef HASH_BUCKET_INSERT_PROBE_SPLIT_TOP_ASSERT_SVH
`define HASH_BUCKET_INSERT_PROBE_SPLIT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HBIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HBIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hbip_pkg.sv =====
package hbip_pkg;

    localparam int CNT_W           = 6;
    localparam int HASH_W          = 52;
    localparam int ID_W            = 44;
    localparam int WORD_W          = 64;
    localparam int TOP_W           = WORD_W - HASH_W;
    localparam int ENTRY_W         = HASH_W + ID_W;
    localparam int HASH_SHIFT      = 8;
    localparam int DEF_MAX_ENTRIES = 32;
    localparam int Q_DEPTH         = 2;
    localparam int Q_AW            = $clog2(Q_DEPTH);
    localparam int Q_FW            = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_SPLIT  = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [2:0] K_CAND  = 3'd0;
    localparam logic [2:0] K_LEND  = 3'd1;
    localparam logic [2:0] K_MOVED = 3'd2;
    localparam logic [2:0] K_INS   = 3'd3;
    localparam logic [2:0] K_FULL  = 3'd4;
    localparam logic [2:0] K_SEND  = 3'd5;

    typedef struct packed {
        logic [1:0]        action;
        logic [HASH_W-1:0] hash;
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] suffix;
    } t_cmd;

endpackage

// ===== rtl/core/hbip_front.sv =====
module hbip_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_action,
    input  logic [hbip_pkg::WORD_W-1:0] i_key_hash,
    input  logic [hbip_pkg::ID_W-1:0]  i_key_id,
    input  logic [hbip_pkg::WORD_W-1:0] i_split_mask,
    input  logic [hbip_pkg::WORD_W-1:0] i_split_suffix,
    output logic                       o_cmd_valid,
    output hbip_pkg::t_cmd             o_cmd,
    input  logic                       i_cmd_pop
);
    import hbip_pkg::*;

    t_cmd            r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_FW-1:0] r_fill, n_fill;
    logic            push;
    logic            pop;
    t_cmd            cmd_in;
    logic [WORD_W-1:0] hash_sh;

    assign o_stall     = (r_fill == Q_FW'(Q_DEPTH));
    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rp];

    assign hash_sh = i_key_hash >> HASH_SHIFT;

    always_comb begin
        cmd_in.action = i_action;
        cmd_in.hash   = hash_sh[HASH_W-1:0];
        cmd_in.id     = i_key_id;
        cmd_in.mask   = i_split_mask >> HASH_SHIFT;
        cmd_in.suffix = i_split_suffix >> HASH_SHIFT;
    end

    // unused action code is taken and dropped here
    assign push = i_valid && !o_stall && (i_action != ACT_NONE);
    assign pop  = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wp   = push ? r_wp + Q_AW'(1) : r_wp;
        n_rp   = pop ? r_rp + Q_AW'(1) : r_rp;
        n_fill = r_fill;
        if (push && !pop) begin
            n_fill = r_fill + Q_FW'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - Q_FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// ===== rtl/core/hbip_back.sv =====
module hbip_back #(
    parameter int MAX_ENTRIES = hbip_pkg::DEF_MAX_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  hbip_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [2:0]                  o_kind,
    output logic [hbip_pkg::ID_W-1:0]   o_out_id,
    output logic [hbip_pkg::HASH_W-1:0] o_out_hash_bits,
    output logic [hbip_pkg::CNT_W-1:0]  o_entries_held,
    output logic                        o_last
);
    import hbip_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CNT  = 4'b0010,
        S_WALK = 4'b0100,
        S_END  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_keep, n_keep;
    logic [CNT_W-1:0] r_nmov, n_nmov;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_held, n_held;
    logic [2:0]       r_end_kind, n_end_kind;

    logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
    logic [ENTRY_W-1:0] r_rd_data;
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic              r_o_valid;
    logic [2:0]        r_o_kind;
    logic [ID_W-1:0]   r_o_id;
    logic [HASH_W-1:0] r_o_hash;
    logic [CNT_W-1:0]  r_o_held;
    logic              r_o_last;

    logic              out_load;
    logic [2:0]        out_kind;
    logic [ID_W-1:0]   out_id;
    logic [HASH_W-1:0] out_hash;
    logic              out_last;

    logic [HASH_W-1:0] rd_hash;
    logic [ID_W-1:0]   rd_id;
    logic [WORD_W-1:0] word;
    logic              hit_split, hit_look, is_split, need_out, out_free, last_entry;
    logic [CNT_W-1:0]  idx_inc;

    assign rd_hash    = r_rd_data[HASH_W-1:0];
    assign rd_id      = r_rd_data[HASH_W +: ID_W];
    assign word       = {rd_id[ID_W-1 -: TOP_W], rd_hash};
    assign hit_split  = ((r_cmd.mask & word) == r_cmd.suffix);
    assign hit_look   = (rd_hash == r_cmd.hash);
    assign is_split   = (r_cmd.action == ACT_SPLIT);
    assign need_out   = is_split ? hit_split : hit_look;
    assign out_free   = !r_o_valid || !i_stall;
    assign idx_inc    = r_idx + CNT_W'(1);
    assign last_entry = (idx_inc == r_count);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_keep     = r_keep;
        n_nmov     = r_nmov;
        n_count    = r_count;
        n_held     = r_held;
        n_end_kind = r_end_kind;
        o_cmd_pop  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = r_rd_data;
        out_load   = 1'b0;
        out_kind   = r_end_kind;
        out_id     = '0;
        out_hash   = '0;
        out_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_keep    = '0;
                    n_nmov    = '0;
                    n_held    = r_count;
                    case (i_cmd.action)
                        ACT_INSERT: begin
                            n_state = S_END;
                            if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                                n_end_kind = K_FULL;
                            end else begin
                                n_end_kind = K_INS;
                                wr_en      = 1'b1;
                                wr_addr    = r_count[AW-1:0];
                                wr_data    = {i_cmd.id, i_cmd.hash};
                                n_count    = r_count + CNT_W'(1);
                                n_held     = n_count;
                            end
                        end
                        ACT_LOOKUP: begin
                            n_end_kind = K_LEND;
                            if (r_count == '0) begin
                                n_state = S_END;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_end_kind = K_SEND;
                            if (r_count == '0) begin
                                n_state = S_END;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_CNT;
                            end
                        end
                    endcase
                end
            end
            S_CNT: begin
                // first pass: count movers so every result carries the final count
                if (hit_split) begin
                    n_nmov = r_nmov + CNT_W'(1);
                end
                rd_en = 1'b1;
                if (last_entry) begin
                    n_idx   = '0;
                    n_held  = r_count - n_nmov;
                    n_state = S_WALK;
                end else begin
                    rd_addr = idx_inc[AW-1:0];
                    n_idx   = idx_inc;
                end
            end
            S_WALK: begin
                if (!need_out || out_free) begin
                    if (need_out) begin
                        out_load = 1'b1;
                        out_kind = is_split ? K_MOVED : K_CAND;
                        out_id   = rd_id;
                        out_hash = is_split ? rd_hash : '0;
                        out_last = 1'b0;
                    end
                    if (is_split && !hit_split) begin
                        wr_en   = 1'b1;
                        wr_addr = r_keep[AW-1:0];
                        n_keep  = r_keep + CNT_W'(1);
                    end
                    if (last_entry) begin
                        n_state = S_END;
                        if (is_split) begin
                            n_count = r_held;
                        end
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = idx_inc[AW-1:0];
                        n_idx   = idx_inc;
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_keep     <= n_keep;
        r_nmov     <= n_nmov;
        r_held     <= n_held;
        r_end_kind <= n_end_kind;
        if (out_load) begin
            r_o_kind <= out_kind;
            r_o_id   <= out_id;
            r_o_hash <= out_hash;
            r_o_held <= r_held;
            r_o_last <= out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_valid         = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_out_id        = r_o_id;
    assign o_out_hash_bits = r_o_hash;
    assign o_entries_held  = r_o_held;
    assign o_last          = r_o_last;

endmodule

// ===== rtl/core/hash_bucket_insert_probe_split_top.sv =====
// Extendible hash bucket: insert, hash-filtered lookup and split.
// Input channel: i_in_valid / o_in_stall, one request per accepted cycle.
// Output channel: o_out_valid / i_out_stall, one result per accepted cycle;
// o_last marks the final result of each request.
// A two-deep command queue parts the front from the execution unit, so up to
// two requests are taken while the back end is busy. Action 3 is taken and
// produces no result.
// Steps per request, N being the entries held:
//   insert      writes the entry unless the bucket is full, then gives its result
//   lookup      walks the N entries, then gives the closing result
//   split       a counting pass then a compacting pass over the N entries
// Each pass visits one entry per cycle while no stalled receiver holds it; the
// compacting pass reads one entry and writes back a kept one in the same cycle.
// A stalled receiver holds the walk at the next entry that needs a result.
// Reset clears the entry count, the command queue and the output valid flag;
// entry memory is not cleared.
module hash_bucket_insert_probe_split_top #(
    parameter int MAX_ENTRIES = hbip_pkg::DEF_MAX_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [hbip_pkg::WORD_W-1:0]  i_key_hash,
    input  logic [hbip_pkg::ID_W-1:0]    i_key_id,
    input  logic [hbip_pkg::WORD_W-1:0]  i_split_mask,
    input  logic [hbip_pkg::WORD_W-1:0]  i_split_suffix,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [2:0]                   o_kind,
    output logic [hbip_pkg::ID_W-1:0]    o_out_id,
    output logic [hbip_pkg::HASH_W-1:0]  o_out_hash_bits,
    output logic [hbip_pkg::CNT_W-1:0]   o_entries_held,
    output logic                         o_last
);
    import hbip_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    hbip_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_action       (i_action),
        .i_key_hash     (i_key_hash),
        .i_key_id       (i_key_id),
        .i_split_mask   (i_split_mask),
        .i_split_suffix (i_split_suffix),
        .o_cmd_valid    (cmd_valid),
        .o_cmd          (cmd),
        .i_cmd_pop      (cmd_pop)
    );

    hbip_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_kind          (o_kind),
        .o_out_id        (o_out_id),
        .o_out_hash_bits (o_out_hash_bits),
        .o_entries_held  (o_entries_held),
        .o_last          (o_last)
    );

endmodule

// ===== rtl/core/hbip_checker.sv =====
`include "hash_bucket_insert_probe_split_top_assert.svh"

module hbip_checker #(
    parameter int MAX_ENTRIES = hbip_pkg::DEF_MAX_ENTRIES
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [2:0]                  o_kind,
    input logic [hbip_pkg::HASH_W-1:0] o_out_hash_bits,
    input logic [hbip_pkg::CNT_W-1:0]  o_entries_held,
    input logic                        o_last
);
    import hbip_pkg::*;

    `HBIP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_kind) && $stable(o_entries_held), "stalled result changed")
    `HBIP_ASSERT_NOW(a_last_kind, i_clk, i_rst_n, o_out_valid && o_last, o_kind == K_LEND || o_kind == K_SEND || o_kind == K_INS || o_kind == K_FULL, "closing result has wrong kind")
    `HBIP_ASSERT_NOW(a_mid_kind, i_clk, i_rst_n, o_out_valid && !o_last, o_kind == K_CAND || o_kind == K_MOVED, "non-closing result has wrong kind")
    `HBIP_ASSERT_NOW(a_cand_hash, i_clk, i_rst_n, o_out_valid && o_kind == K_CAND, o_out_hash_bits == '0, "candidate carries hash bits")
    `HBIP_ASSERT_NOW(a_held_max, i_clk, i_rst_n, o_out_valid, o_entries_held <= CNT_W'(MAX_ENTRIES), "entry count above bucket size")

endmodule

bind hash_bucket_insert_probe_split_top hbip_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_hbip_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_kind          (o_kind),
    .o_out_hash_bits (o_out_hash_bits),
    .o_entries_held  (o_entries_held),
    .o_last          (o_last)
);
